// File: src/lwu_pkg.sv
`default_nettype none

package lwu_pkg;

    // Word and field geometry
    localparam int WORD_W       = 64;
    localparam int WIDE_W       = 12;
    localparam int NARROW_W     = 6;
    localparam int WIDE_DEPTH   = 4096;
    localparam int NARROW_DEPTH = 64;
    localparam int NARROW_CNT   = 4;
    localparam int NARROW_SPAN  = NARROW_W * NARROW_CNT;

    // Field positions inside the pixel word
    localparam int WIDE_DEC_LSB   = 0;
    localparam int WIDE_ENC_LSB   = 48;
    localparam int NARROW_DEC_LSB = 0;
    localparam int NARROW_ENC_LSB = 36;

    // Configuration register indexes
    localparam logic CFG_FIX_ENABLE = 1'b0;
    localparam logic CFG_WIDTH_MODE = 1'b1;

    // Counter width mode codes
    localparam logic [1:0] MODE_OTHER  = 2'd0;
    localparam logic [1:0] MODE_NARROW = 2'd1;
    localparam logic [1:0] MODE_WIDE   = 2'd2;

    typedef enum logic [1:0] {
        FIX_PASS,
        FIX_NARROW,
        FIX_WIDE
    } t_fix_sel;

    typedef enum logic [1:0] {
        INIT_CLEAR,
        INIT_WALK,
        INIT_DONE
    } t_init_st;

    typedef logic [NARROW_W-1:0] t_rom6 [NARROW_DEPTH];

    // Six-bit counter step: taps 0 and 5, inverted when the low five bits are zero
    function automatic logic [NARROW_W-1:0] f_lfsr6_next(input logic [NARROW_W-1:0] c);
        logic fb;
        fb = c[0] ^ c[5];
        if (c[4:0] == 5'd0) begin
            fb = ~fb;
        end
        return {c[NARROW_W-2:0], fb};
    endfunction

    // Twelve-bit counter step: taps 0, 3, 5, 11, inverted when the low eleven bits are zero
    function automatic logic [WIDE_W-1:0] f_lfsr12_next(input logic [WIDE_W-1:0] c);
        logic fb;
        fb = c[0] ^ c[3] ^ c[5] ^ c[11];
        if (c[10:0] == 11'd0) begin
            fb = ~fb;
        end
        return {c[WIDE_W-2:0], fb};
    endfunction

    // Count to code for the six-bit counter
    function automatic t_rom6 f_narrow_enc();
        t_rom6               tab;
        logic [NARROW_W-1:0] code;
        code = '0;
        for (int i = 0; i < NARROW_DEPTH; i++) begin
            tab[i] = code;
            code   = f_lfsr6_next(code);
        end
        return tab;
    endfunction

    // Code to count for the six-bit counter; codes never reached read zero
    function automatic t_rom6 f_narrow_dec();
        t_rom6               tab;
        logic [NARROW_W-1:0] code;
        tab  = '{default: '0};
        code = '0;
        for (int i = 0; i < NARROW_DEPTH; i++) begin
            tab[code] = NARROW_W'(i);
            code      = f_lfsr6_next(code);
        end
        return tab;
    endfunction

    localparam t_rom6 NARROW_ENC_ROM = f_narrow_enc();
    localparam t_rom6 NARROW_DEC_ROM = f_narrow_dec();

endpackage

`default_nettype wire

// File: src/lwu_if.sv
`default_nettype none

// Raw pixel word channel
interface lwu_pix_if;
    logic                       valid;
    logic                       ready;
    logic [lwu_pkg::WORD_W-1:0] pixel_word;

    modport source (output valid, output pixel_word, input ready);
    modport sink   (input valid, input pixel_word, output ready);
endinterface

// Repaired pixel word channel
interface lwu_fix_if;
    logic                       valid;
    logic                       ready;
    logic [lwu_pkg::WORD_W-1:0] fixed_word;

    modport source (output valid, output fixed_word, input ready);
    modport sink   (input valid, input fixed_word, output ready);
endinterface

// Configuration write channel
interface lwu_cfg_if;
    logic       valid;
    logic       ready;
    logic       index;
    logic [1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: src/lwu_wide_rom.sv
`default_nettype none

// Twelve-bit decode and encode tables in two block memories.
// After reset the decode memory is cleared, then the counter
// sequence is walked once, writing both tables.
module lwu_wide_rom (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_rd_en,
    input  wire logic [lwu_pkg::WIDE_W-1:0]  i_dec_addr,
    input  wire logic [lwu_pkg::WIDE_W-1:0]  i_enc_addr,
    output      logic [lwu_pkg::WIDE_W-1:0]  o_dec_q,
    output      logic [lwu_pkg::WIDE_W-1:0]  o_enc_q,
    output      logic                        o_init_done
);
    import lwu_pkg::*;

    logic [WIDE_W-1:0] r_dec_mem [WIDE_DEPTH];
    logic [WIDE_W-1:0] r_enc_mem [WIDE_DEPTH];

    t_init_st          r_st, n_st;
    logic [WIDE_W-1:0] r_cnt, n_cnt;
    logic [WIDE_W-1:0] r_code, n_code;

    logic              dec_we, enc_we;
    logic [WIDE_W-1:0] dec_waddr, dec_wdata;
    logic              cnt_last;

    assign cnt_last = (r_cnt == {WIDE_W{1'b1}});

    // Build sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= INIT_CLEAR;
            r_cnt  <= '0;
            r_code <= '0;
        end else begin
            r_st   <= n_st;
            r_cnt  <= n_cnt;
            r_code <= n_code;
        end
    end

    // Next state and write controls
    always_comb begin
        n_st      = r_st;
        n_cnt     = r_cnt;
        n_code    = r_code;
        dec_we    = 1'b0;
        enc_we    = 1'b0;
        dec_waddr = r_cnt;
        dec_wdata = '0;
        case (r_st)
            INIT_CLEAR: begin
                dec_we = 1'b1;
                n_cnt  = r_cnt + 1'b1;
                if (cnt_last) begin
                    n_st   = INIT_WALK;
                    n_code = '0;
                end
            end
            INIT_WALK: begin
                dec_we    = 1'b1;
                enc_we    = 1'b1;
                dec_waddr = r_code;
                dec_wdata = r_cnt;
                n_cnt     = r_cnt + 1'b1;
                n_code    = f_lfsr12_next(r_code);
                if (cnt_last) begin
                    n_st = INIT_DONE;
                end
            end
            INIT_DONE: begin
                n_st = INIT_DONE;
            end
            default: begin
                n_st = INIT_CLEAR;
            end
        endcase
    end

    // Decode memory: code to count
    always_ff @(posedge i_clk) begin
        if (dec_we) begin
            r_dec_mem[dec_waddr] <= dec_wdata;
        end
        if (i_rd_en) begin
            o_dec_q <= r_dec_mem[i_dec_addr];
        end
    end

    // Encode memory: count to code
    always_ff @(posedge i_clk) begin
        if (enc_we) begin
            r_enc_mem[r_cnt] <= r_code;
        end
        if (i_rd_en) begin
            o_enc_q <= r_enc_mem[i_enc_addr];
        end
    end

    assign o_init_done = (r_st == INIT_DONE);

endmodule

`default_nettype wire

// File: src/lwu_narrow_map.sv
`default_nettype none

// Six-bit field lookups: four decodes and four re-encodes, registered
module lwu_narrow_map (
    input  wire logic                             i_clk,
    input  wire logic                             i_en,
    input  wire logic [lwu_pkg::WORD_W-1:0]       i_word,
    output      logic [lwu_pkg::NARROW_SPAN-1:0]  o_dec,
    output      logic [lwu_pkg::NARROW_SPAN-1:0]  o_enc
);
    import lwu_pkg::*;

    logic [NARROW_SPAN-1:0] n_dec, n_enc;

    // One table read per field
    always_comb begin
        for (int k = 0; k < NARROW_CNT; k++) begin
            n_dec[k*NARROW_W +: NARROW_W] =
                NARROW_DEC_ROM[i_word[NARROW_DEC_LSB + k*NARROW_W +: NARROW_W]];
            n_enc[k*NARROW_W +: NARROW_W] =
                NARROW_ENC_ROM[i_word[NARROW_ENC_LSB + k*NARROW_W +: NARROW_W]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_dec <= n_dec;
            o_enc <= n_enc;
        end
    end

endmodule

`default_nettype wire

// File: src/pixel_word_lfsr_unscramble_top.sv
`default_nettype none

// Pixel word counter unscrambler.
// i_pix carries raw 64-bit pixel words in, o_fix carries repaired words out;
// a word moves on a channel when valid and ready are both high.
// i_cfg writes register 0 (fix enable) and register 1 (counter width mode:
// 1 six-bit, 2 twelve-bit, other codes pass through); it is always ready. The user
// must write it only while no word is in flight; the block does not enforce it.
// Throughput: one word per cycle while o_fix.ready is high. An accepted word
// passes the input register, the table read and the merge register, and
// o_fix.valid rises once it sits in the merge register.
// The twelve-bit tables sit in two 4096-entry memories whose registered
// read port sets the middle stage.
// After reset the twelve-bit tables are rebuilt: i_pix.ready stays low while
// the decode memory is cleared and the counter sequence is walked.
// When o_fix.ready is low the pipeline fills its empty stages and then holds;
// i_pix.ready drops only when all three stages are occupied.
module pixel_word_lfsr_unscramble_top (
    input wire logic i_clk,
    input wire logic i_rst_n,
    lwu_pix_if.sink  i_pix,
    lwu_cfg_if.sink  i_cfg,
    lwu_fix_if.source o_fix
);
    import lwu_pkg::*;

    logic       r_fix_enable;
    logic [1:0] r_width_mode;
    t_fix_sel   in_sel;

    logic               r_v1, r_v2, r_v3;
    logic               en1, en2, en3;
    logic               init_done, accept;
    logic [WORD_W-1:0]  r_s1_word, r_s2_word, r_s3_word;
    t_fix_sel           r_s1_sel, r_s2_sel;
    logic [WIDE_W-1:0]  wide_dec, wide_enc;
    logic [NARROW_SPAN-1:0] narrow_dec, narrow_enc;
    logic [WORD_W-1:0]  n_fixed;

    // Configuration registers
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fix_enable <= 1'b0;
            r_width_mode <= MODE_OTHER;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_FIX_ENABLE: r_fix_enable <= i_cfg.data[0];
                CFG_WIDTH_MODE: r_width_mode <= i_cfg.data;
                default:        r_fix_enable <= r_fix_enable;
            endcase
        end
    end

    // Fix selection applied to each accepted word
    always_comb begin
        in_sel = FIX_PASS;
        if (r_fix_enable) begin
            case (r_width_mode)
                MODE_NARROW: in_sel = FIX_NARROW;
                MODE_WIDE:   in_sel = FIX_WIDE;
                default:     in_sel = FIX_PASS;
            endcase
        end
    end

    // Stage enables: a stage loads when it is empty or its successor moves
    assign en3         = !r_v3 || o_fix.ready;
    assign en2         = !r_v2 || en3;
    assign en1         = !r_v1 || en2;
    assign i_pix.ready = init_done && en1;
    assign accept      = i_pix.valid && i_pix.ready;

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= accept;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
            if (en3) begin
                r_v3 <= r_v2;
            end
        end
    end

    // Stage 1: input register
    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_s1_word <= i_pix.pixel_word;
            r_s1_sel  <= in_sel;
        end
    end

    // Stage 2: table reads
    lwu_wide_rom u_wide_rom (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_en     (en2),
        .i_dec_addr  (r_s1_word[WIDE_DEC_LSB +: WIDE_W]),
        .i_enc_addr  (r_s1_word[WIDE_ENC_LSB +: WIDE_W]),
        .o_dec_q     (wide_dec),
        .o_enc_q     (wide_enc),
        .o_init_done (init_done)
    );

    lwu_narrow_map u_narrow_map (
        .i_clk  (i_clk),
        .i_en   (en2),
        .i_word (r_s1_word),
        .o_dec  (narrow_dec),
        .o_enc  (narrow_enc)
    );

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_s2_word <= r_s1_word;
            r_s2_sel  <= r_s1_sel;
        end
    end

    // Stage 3: merge the looked-up fields into the word
    always_comb begin
        n_fixed = r_s2_word;
        case (r_s2_sel)
            FIX_WIDE: begin
                n_fixed[WIDE_DEC_LSB +: WIDE_W] = wide_dec;
                n_fixed[WIDE_ENC_LSB +: WIDE_W] = wide_enc;
            end
            FIX_NARROW: begin
                n_fixed[NARROW_DEC_LSB +: NARROW_SPAN] = narrow_dec;
                n_fixed[NARROW_ENC_LSB +: NARROW_SPAN] = narrow_enc;
            end
            default: begin
                n_fixed = r_s2_word;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_s3_word <= n_fixed;
        end
    end

    assign o_fix.valid      = r_v3;
    assign o_fix.fixed_word = r_s3_word;

endmodule

`default_nettype wire

// File: tb/sv/pixel_word_lfsr_unscramble_top_tb.sv
`timescale 1ns / 1ps

module pixel_word_lfsr_unscramble_top_tb;

    import lwu_pkg::*;

    localparam int          CLK_HALF      = 2;
    localparam int          RESET_CYCLES  = 10;
    localparam int          PIPE_LAT      = 3;
    localparam int          RANDOM_WORDS  = 1100;
    localparam int          HOLD_CYCLES   = 400;
    localparam int          HOLD_AFTER    = 150;
    localparam int          STALL_LIMIT   = 40000;
    localparam int          REPORT_MAX    = 10;
    localparam logic [1:0]  MODE_RESERVED = 2'd3;
    // Every counter field, wide and narrow, decoded or re-encoded
    localparam logic [WORD_W-1:0] FIELD_BITS = 64'h0FFF_FFF0_00FF_FFFF;
    localparam logic [WORD_W-1:0] ALL_ONES   = {WORD_W{1'b1}};

    typedef enum int {
        ROW_PLAIN,
        ROW_NARROW_UNSEEN,
        ROW_WIDE_UNSEEN
    } t_row_kind;

    typedef struct {
        bit                en;
        logic [1:0]        mode;
        logic [WORD_W-1:0] word;
        bit                typed;
        logic [WORD_W-1:0] exp_word;
        t_row_kind         kind;
    } t_stim_row;

    logic i_clk;
    logic i_rst_n;

    lwu_pix_if pix_if ();
    lwu_cfg_if cfg_if ();
    lwu_fix_if fix_if ();

    pixel_word_lfsr_unscramble_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_if),
        .i_cfg   (cfg_if),
        .o_fix   (fix_if)
    );

    // Counter tables rebuilt locally from the two LFSR sequences
    logic [WIDE_W-1:0]   dec_wide_tab   [WIDE_DEPTH];
    logic [WIDE_W-1:0]   enc_wide_tab   [WIDE_DEPTH];
    logic [NARROW_W-1:0] dec_narrow_tab [NARROW_DEPTH];
    logic [NARROW_W-1:0] enc_narrow_tab [NARROW_DEPTH];
    int                  wide_unseen    [$];
    int                  narrow_unseen  [$];

    // Register copies as seen by the block
    bit         fix_en_q;
    logic [1:0] width_mode_q;

    logic [WORD_W-1:0] fixed_expect_q [$];
    t_stim_row         directed_rows  [$];
    int                mismatch_cnt;
    int                results_seen;

    initial begin
        i_clk = 1'b0;
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    function automatic void build_count_tables();
        logic [WIDE_W-1:0]   wc;
        logic [NARROW_W-1:0] nc;
        logic                fb;
        bit                  wide_hit   [WIDE_DEPTH];
        bit                  narrow_hit [NARROW_DEPTH];
        for (int i = 0; i < WIDE_DEPTH; i++) begin
            dec_wide_tab[i] = '0;
            wide_hit[i]     = 1'b0;
        end
        for (int i = 0; i < NARROW_DEPTH; i++) begin
            dec_narrow_tab[i] = '0;
            narrow_hit[i]     = 1'b0;
        end
        // six-bit walk: taps 0 and 5, inverted on low five bits zero
        nc = '0;
        for (int i = 0; i < NARROW_DEPTH; i++) begin
            dec_narrow_tab[nc] = NARROW_W'(i);
            enc_narrow_tab[i]  = nc;
            narrow_hit[nc]     = 1'b1;
            fb = nc[0] ^ nc[5];
            if (nc[4:0] == '0) fb = ~fb;
            nc = {nc[4:0], fb};
        end
        // twelve-bit walk: taps 0, 3, 5, 11, inverted on low eleven bits zero
        wc = '0;
        for (int i = 0; i < WIDE_DEPTH; i++) begin
            dec_wide_tab[wc] = WIDE_W'(i);
            enc_wide_tab[i]  = wc;
            wide_hit[wc]     = 1'b1;
            fb = wc[0] ^ wc[3] ^ wc[5] ^ wc[11];
            if (wc[10:0] == '0) fb = ~fb;
            wc = {wc[10:0], fb};
        end
        for (int i = 0; i < WIDE_DEPTH; i++)
            if (!wide_hit[i]) wide_unseen.push_back(i);
        for (int i = 0; i < NARROW_DEPTH; i++)
            if (!narrow_hit[i]) narrow_unseen.push_back(i);
    endfunction

    // Expected repaired word under the current register copies
    function automatic logic [WORD_W-1:0] predict_fixed(input logic [WORD_W-1:0] w);
        logic [WORD_W-1:0] r;
        r = w;
        if (fix_en_q) begin
            if (width_mode_q == MODE_WIDE) begin
                r[WIDE_DEC_LSB +: WIDE_W] = dec_wide_tab[w[WIDE_DEC_LSB +: WIDE_W]];
                r[WIDE_ENC_LSB +: WIDE_W] = enc_wide_tab[w[WIDE_ENC_LSB +: WIDE_W]];
            end else if (width_mode_q == MODE_NARROW) begin
                for (int k = 0; k < NARROW_CNT; k++) begin
                    r[NARROW_DEC_LSB + NARROW_W*k +: NARROW_W] =
                        dec_narrow_tab[w[NARROW_DEC_LSB + NARROW_W*k +: NARROW_W]];
                    r[NARROW_ENC_LSB + NARROW_W*k +: NARROW_W] =
                        enc_narrow_tab[w[NARROW_ENC_LSB + NARROW_W*k +: NARROW_W]];
                end
            end
        end
        return r;
    endfunction

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic void add_row(input bit en, input logic [1:0] mode,
                                    input logic [WORD_W-1:0] word, input bit typed,
                                    input t_row_kind kind);
        t_stim_row row;
        row.en       = en;
        row.mode     = mode;
        row.word     = word;
        row.typed    = typed;
        row.exp_word = word;
        row.kind     = kind;
        directed_rows.push_back(row);
    endfunction

    // Offer one word, hold it until taken, then maybe idle a while
    task automatic send_word(input logic [WORD_W-1:0] w,
                             input logic [WORD_W-1:0] exp_w, input bit no_gaps);
        int gap;
        pix_if.valid      <= 1'b1;
        pix_if.pixel_word <= w;
        @(posedge i_clk);
        while (!pix_if.ready) @(posedge i_clk);
        fixed_expect_q.push_back(exp_w);
        gap = no_gaps ? 0 : pick_gap();
        if (gap > 0) begin
            pix_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Drain everything in flight before touching registers
    task automatic settle_pipeline();
        pix_if.valid <= 1'b0;
        @(posedge i_clk);
        while (fixed_expect_q.size() != 0) @(posedge i_clk);
        repeat (PIPE_LAT + 2) @(posedge i_clk);
    endtask

    // Write both registers back to back, valid held across them
    task automatic write_config(input bit en, input logic [1:0] mode);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= CFG_FIX_ENABLE;
        cfg_if.data  <= {1'b0, en};
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        fix_en_q = en;
        cfg_if.index <= CFG_WIDTH_MODE;
        cfg_if.data  <= mode;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        width_mode_q = mode;
        cfg_if.valid <= 1'b0;
    endtask

    // Result checker against the oldest expectation
    initial begin
        mismatch_cnt = 0;
        results_seen = 0;
    end

    always @(posedge i_clk) begin
        logic [WORD_W-1:0] want;
        if (i_rst_n && fix_if.valid && fix_if.ready) begin
            results_seen++;
            if (fixed_expect_q.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= REPORT_MAX)
                    $display("unexpected word %0d: got %h", results_seen,
                             fix_if.fixed_word);
            end else begin
                want = fixed_expect_q.pop_front();
                if (fix_if.fixed_word !== want) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= REPORT_MAX)
                        $display("word %0d fixed_word: expected %h got %h",
                                 results_seen, want, fix_if.fixed_word);
                end
            end
        end
    end

    // Output side: random stalls, quiet stretches, one long hold-off
    initial begin
        int  gap;
        int  quiet_left;
        bit  held_off;
        quiet_left = 0;
        held_off   = 1'b0;
        fix_if.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (!held_off && results_seen >= HOLD_AFTER) begin
                held_off = 1'b1;
                fix_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                if (quiet_left > 0) begin
                    quiet_left--;
                    gap = 0;
                end else begin
                    if ($urandom_range(0, 49) == 0) quiet_left = $urandom_range(30, 100);
                    gap = pick_gap();
                end
                if (gap > 0) begin
                    fix_if.ready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
                fix_if.ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // Watchdog on cycles without any handshake
    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((pix_if.valid && pix_if.ready) || (fix_if.valid && fix_if.ready) ||
                (cfg_if.valid && cfg_if.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
        $display("FAILED: results differ");
        $finish;
    end

    // Stimulus: directed table, then random phases
    initial begin
        logic [WORD_W-1:0] w;
        logic [WORD_W-1:0] mask;
        t_stim_row         row;
        int                sent_random;
        int                phase;
        int                n_words;
        bit                en;
        logic [1:0]        mode;
        bit                no_gaps;

        build_count_tables();
        fix_en_q     = 1'b0;
        width_mode_q = MODE_OTHER;

        i_rst_n           <= 1'b0;
        pix_if.valid      <= 1'b0;
        pix_if.pixel_word <= '0;
        cfg_if.valid      <= 1'b0;
        cfg_if.index      <= CFG_FIX_ENABLE;
        cfg_if.data       <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // pass-through rows carry their own expected word
        add_row(1'b0, MODE_OTHER,    ALL_ONES,               1'b1, ROW_PLAIN);
        add_row(1'b0, MODE_OTHER,    '0,                     1'b1, ROW_PLAIN);
        add_row(1'b0, MODE_WIDE,     64'hA5A5_5A5A_0FF0_F00F, 1'b1, ROW_PLAIN);
        add_row(1'b0, MODE_NARROW,   64'hA5A5_5A5A_0FF0_F00F, 1'b1, ROW_PLAIN);
        add_row(1'b1, MODE_OTHER,    64'hDEAD_BEEF_0123_4567, 1'b1, ROW_PLAIN);
        add_row(1'b1, MODE_RESERVED, 64'hDEAD_BEEF_0123_4567, 1'b1, ROW_PLAIN);
        add_row(1'b1, MODE_RESERVED, ALL_ONES,               1'b1, ROW_PLAIN);
        // six-bit fields
        add_row(1'b1, MODE_NARROW,   '0,                     1'b0, ROW_PLAIN);
        add_row(1'b1, MODE_NARROW,   ALL_ONES,               1'b0, ROW_PLAIN);
        add_row(1'b1, MODE_NARROW,   64'h0FFF_FFF0_0000_0000, 1'b0, ROW_PLAIN);
        add_row(1'b1, MODE_NARROW,   64'h5555_5555_5555_5555, 1'b0, ROW_NARROW_UNSEEN);
        add_row(1'b1, MODE_NARROW,   64'hF000_000F_FF00_0000, 1'b0, ROW_PLAIN);
        add_row(1'b1, MODE_NARROW,   64'h0000_0200_0000_0020, 1'b0, ROW_PLAIN);
        // twelve-bit fields
        add_row(1'b1, MODE_WIDE,     '0,                     1'b0, ROW_PLAIN);
        add_row(1'b1, MODE_WIDE,     ALL_ONES,               1'b0, ROW_PLAIN);
        add_row(1'b1, MODE_WIDE,     64'h0FFF_0000_0000_0FFF, 1'b0, ROW_PLAIN);
        add_row(1'b1, MODE_WIDE,     64'hF000_FFFF_FFFF_F000, 1'b0, ROW_PLAIN);
        add_row(1'b1, MODE_WIDE,     64'h8001_8001_8001_8001, 1'b0, ROW_WIDE_UNSEEN);
        add_row(1'b1, MODE_WIDE,     64'h0800_0000_0000_0800, 1'b0, ROW_PLAIN);
        add_row(1'b1, MODE_WIDE,     64'h0008_0000_0000_0008, 1'b0, ROW_PLAIN);
        // fix turned off again
        add_row(1'b0, MODE_WIDE,     ALL_ONES,               1'b1, ROW_PLAIN);
        add_row(1'b1, MODE_OTHER,    ALL_ONES,               1'b1, ROW_PLAIN);

        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            if (row.en != fix_en_q || row.mode != width_mode_q) begin
                settle_pipeline();
                write_config(row.en, row.mode);
            end
            w = row.word;
            // codes the counter never reaches must decode to zero
            if (row.kind == ROW_NARROW_UNSEEN && narrow_unseen.size() != 0) begin
                for (int k = 0; k < NARROW_CNT; k++)
                    w[NARROW_DEC_LSB + NARROW_W*k +: NARROW_W] =
                        NARROW_W'(narrow_unseen[k % narrow_unseen.size()]);
            end else if (row.kind == ROW_WIDE_UNSEEN && wide_unseen.size() != 0) begin
                w[WIDE_DEC_LSB +: WIDE_W] = WIDE_W'(wide_unseen[0]);
            end
            send_word(w, row.typed ? row.exp_word : predict_fixed(w), 1'b0);
        end

        // random phases, extremes first, then mostly the two active modes
        sent_random = 0;
        phase       = 0;
        while (sent_random < RANDOM_WORDS) begin
            case (phase)
                0: begin en = 1'b1; mode = MODE_WIDE;     end
                1: begin en = 1'b1; mode = MODE_NARROW;   end
                2: begin en = 1'b0; mode = MODE_OTHER;    end
                3: begin en = 1'b1; mode = MODE_RESERVED; end
                4: begin en = 1'b0; mode = MODE_RESERVED; end
                5: begin en = 1'b1; mode = MODE_OTHER;    end
                default: begin
                    if ($urandom_range(0, 4) == 0) begin
                        en   = 1'($urandom_range(0, 1));
                        mode = 2'($urandom_range(0, 3));
                    end else begin
                        en   = 1'b1;
                        mode = $urandom_range(0, 1) ? MODE_WIDE : MODE_NARROW;
                    end
                end
            endcase
            settle_pipeline();
            write_config(en, mode);
            no_gaps = ($urandom_range(0, 3) == 0);
            n_words = $urandom_range(40, 120);
            repeat (n_words) begin
                w = {$urandom, $urandom};
                mask = FIELD_BITS;
                case ($urandom_range(0, 7))
                    0: w = w | mask;
                    1: w = w & ~mask;
                    default: ;
                endcase
                send_word(w, predict_fixed(w), no_gaps);
                sent_random++;
            end
            phase++;
        end

        // drain and let the pipeline go quiet
        pix_if.valid <= 1'b0;
        while (fixed_expect_q.size() != 0) @(posedge i_clk);
        repeat (PIPE_LAT * 4) @(posedge i_clk);
        if (mismatch_cnt == 0 && fixed_expect_q.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// File: files.f
src/lwu_pkg.sv
src/lwu_if.sv
src/lwu_wide_rom.sv
src/lwu_narrow_map.sv
src/pixel_word_lfsr_unscramble_top.sv
tb/sv/pixel_word_lfsr_unscramble_top_tb.sv
